/* design/prf_pkg.sv */
package prf_pkg;

	// Default sizes of the stores and the data path
	localparam int MAX_TAPS_DEF       = 1024;
	localparam int MAX_PHASE_TAPS_DEF = 64;
	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int COEF_WIDTH_DEF     = 16;

	// Fixed field and register widths
	localparam int COEF_IDX_W = 10;
	localparam int UP_W       = 6;
	localparam int DN_W       = 7;
	localparam int TPP_W      = 7;
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int OFS_W      = 7;

	// Legal ranges of the factors
	localparam int UP_MAX = 32;
	localparam int DN_MAX = 64;

	// Input word modes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_COEF = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UP  = 2'd0,
		CFG_DN  = 2'd1,
		CFG_TPP = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MAC,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_SCALE,
		ST_EMIT
	} prf_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic hist_wr;
		logic coef_wr;
		logic mac_start;
		logic mac_issue;
		logic scale;
		logic out_load;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic ofs_lt_u;
		logic tap_last;
		logic out_busy;
	} dp_sts_t;

endpackage

/* design/prf_ctrl.sv */
module prf_ctrl
	import prf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    mode,
	output logic    item_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	prf_state_t state_q;
	prf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (mode == MODE_COEF) begin
						cmd.coef_wr = 1'b1;
					end else begin
						cmd.hist_wr = 1'b1;
						state_d     = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (sts.ofs_lt_u) begin
					cmd.mac_start = 1'b1;
					state_d       = ST_MAC;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (sts.tap_last) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: begin
				state_d = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/prf_dpath.sv */
module prf_dpath
	import prf_pkg::*;
#(
	parameter int MAX_TAPS       = MAX_TAPS_DEF,
	parameter int MAX_PHASE_TAPS = MAX_PHASE_TAPS_DEF,
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
	parameter int TAPS_W         = $clog2(MAX_PHASE_TAPS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dp_cmd_t                        cmd,
	output dp_sts_t                        sts,
	input  logic [UP_W-1:0]                up,
	input  logic [DN_W-1:0]                dn,
	input  logic [TAPS_W-1:0]              taps,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic [COEF_IDX_W-1:0]          coef_index,
	input  logic signed [COEF_WIDTH-1:0]   coef_value,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           is_last
);

	localparam int HP_W   = $clog2(MAX_PHASE_TAPS);
	localparam int CIDX_W = $clog2(MAX_TAPS);
	localparam int SPAN_W = $clog2(MAX_PHASE_TAPS * UP_MAX + UP_MAX);
	localparam int TA_W0  = (SPAN_W > CIDX_W) ? SPAN_W : CIDX_W;
	localparam int TA_W   = ((TA_W0 > COEF_IDX_W) ? TA_W0 : COEF_IDX_W) + 1;
	localparam int P_W    = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_W  = P_W + $clog2(MAX_PHASE_TAPS + 1);
	localparam int SCL_W  = ACC_W + UP_W + 1;
	localparam int RND_W  = SCL_W + 1;

	localparam logic [TA_W-1:0] TAP_LIMIT = TA_W'(MAX_TAPS);
	localparam logic [HP_W-1:0] HP_LAST   = HP_W'(MAX_PHASE_TAPS - 1);
	localparam logic signed [RND_W-1:0] RND_BIAS = RND_W'(64'd1 << (COEF_WIDTH - 2));
	localparam logic signed [RND_W-1:0] SAT_MAX  = RND_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
	localparam logic signed [RND_W-1:0] SAT_MIN  = -SAT_MAX - RND_W'(1);

	// Stores
	logic signed [SAMPLE_WIDTH-1:0] hist_mem [MAX_PHASE_TAPS];
	logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
	logic [MAX_PHASE_TAPS-1:0]      hvalid_q;

	// Stream state
	logic [HP_W-1:0]   wp_q;
	logic [OFS_W-1:0]  ofs_q;

	// Tap walk
	logic [TAPS_W-1:0] tap_q;
	logic [TA_W-1:0]   addr_q;
	logic [HP_W-1:0]   hidx_q;

	// MAC pipeline
	logic                           mac_en_s1;
	logic                           mac_en_s2;
	logic signed [COEF_WIDTH-1:0]   coef_s1;
	logic signed [SAMPLE_WIDTH-1:0] hist_s1;
	logic                           hval_s1;
	logic                           addr_ok_s1;
	logic signed [COEF_WIDTH-1:0]   coef_sel;
	logic signed [SAMPLE_WIDTH-1:0] hist_sel;
	logic signed [P_W-1:0]          prod_s2;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [SCL_W-1:0]        scaled_q;

	logic [TA_W-1:0]                widx;
	logic signed [RND_W-1:0]        rnd;
	logic signed [RND_W-1:0]        shifted;
	logic signed [SAMPLE_WIDTH-1:0] sat;
	logic [OFS_W-1:0]               ofs_next;

	assign widx     = TA_W'(coef_index);
	assign ofs_next = ofs_q + OFS_W'(dn);

	assign sts.ofs_lt_u = ofs_q < OFS_W'(up);
	assign sts.tap_last = tap_q == TAPS_W'(taps - 1'b1);
	assign sts.out_busy = result_valid & result_stall;

	// Coefficient store: written by mode-one words, read by the tap walk
	always_ff @(posedge clk) begin
		if (cmd.coef_wr && widx < TAP_LIMIT) begin
			coef_mem[widx[CIDX_W-1:0]] <= coef_value;
		end
		coef_s1 <= coef_mem[addr_q[CIDX_W-1:0]];
	end

	// Sample history ring
	always_ff @(posedge clk) begin
		if (cmd.hist_wr) begin
			hist_mem[wp_q] <= sample_in;
		end
		hist_s1 <= hist_mem[hidx_q];
	end

	always_ff @(posedge clk) begin
		hval_s1    <= hvalid_q[hidx_q];
		addr_ok_s1 <= addr_q < TAP_LIMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q  <= '0;
			wp_q      <= '0;
			ofs_q     <= '0;
			mac_en_s1 <= 1'b0;
			mac_en_s2 <= 1'b0;
		end else begin
			mac_en_s1 <= cmd.mac_issue;
			mac_en_s2 <= mac_en_s1;
			if (cmd.hist_wr) begin
				hvalid_q[wp_q] <= 1'b1;
			end
			if (cmd.out_load) begin
				ofs_q <= ofs_next;
			end else if (cmd.finish) begin
				ofs_q <= ofs_q - OFS_W'(up);
				wp_q  <= (wp_q == HP_LAST) ? '0 : wp_q + 1'b1;
			end
		end
	end

	// Walk taps: coefficient address steps by U, history index steps back
	always_ff @(posedge clk) begin
		if (cmd.mac_start) begin
			tap_q  <= '0;
			addr_q <= TA_W'(ofs_q);
			hidx_q <= wp_q;
		end else if (cmd.mac_issue) begin
			tap_q  <= tap_q + 1'b1;
			addr_q <= addr_q + TA_W'(up);
			hidx_q <= (hidx_q == '0) ? HP_LAST : hidx_q - 1'b1;
		end
	end

	// Unwritten history reads as zero; out-of-range taps add nothing
	assign coef_sel = addr_ok_s1 ? coef_s1 : '0;
	assign hist_sel = hval_s1 ? hist_s1 : '0;

	always_ff @(posedge clk) begin
		prod_s2 <= coef_sel * hist_sel;
		if (cmd.mac_start) begin
			acc_q <= '0;
		end else if (mac_en_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.scale) begin
			scaled_q <= acc_q * $signed({1'b0, up});
		end
	end

	// Round half up, then saturate
	always_comb begin
		rnd     = RND_W'(scaled_q) + RND_BIAS;
		shifted = rnd >>> (COEF_WIDTH - 1);
		if (shifted > SAT_MAX) begin
			sat = SAT_MAX[SAMPLE_WIDTH-1:0];
		end else if (shifted < SAT_MIN) begin
			sat = SAT_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			sat = shifted[SAMPLE_WIDTH-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_out <= sat;
			is_last    <= ofs_next >= OFS_W'(up);
		end
	end

endmodule

/* design/polyphase_resampling_fir.sv */
// Rational resampler by U/D as a polyphase FIR. A mode-one word writes one
// Q1.15 coefficient and leaves the block idle. A mode-zero word pushes a
// sample into the history ring and produces zero or more result words, each
// rounded half up and saturated; the last result of a push carries is_last.
// One shared multiply-accumulate unit walks the taps of the active phase one
// per cycle. After the last result of a push is loaded into the output
// register, the block passes through its check state back to idle and takes
// the next word, even if that result is still stalled. History starts out
// cleared; coefficients must be written before they are used. Write
// configuration only while the block is idle.
module polyphase_resampling_fir
	import prf_pkg::*;
#(
	parameter int MAX_TAPS       = MAX_TAPS_DEF,
	parameter int MAX_PHASE_TAPS = MAX_PHASE_TAPS_DEF,
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH     = COEF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	// input words
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           mode,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic [COEF_IDX_W-1:0]          coef_index,
	input  logic signed [COEF_WIDTH-1:0]   coef_value,
	// result words
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           is_last
);

	localparam int TAPS_W = $clog2(MAX_PHASE_TAPS + 1);

	logic [UP_W-1:0]   up_q;
	logic [DN_W-1:0]   dn_q;
	logic [TPP_W-1:0]  tpp_q;
	logic [UP_W-1:0]   up_eff;
	logic [DN_W-1:0]   dn_eff;
	logic [TAPS_W-1:0] taps_eff;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Configuration registers; an unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q  <= UP_W'(1);
			dn_q  <= DN_W'(1);
			tpp_q <= TPP_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UP:  up_q  <= cfg_data[UP_W-1:0];
				CFG_DN:  dn_q  <= cfg_data[DN_W-1:0];
				CFG_TPP: tpp_q <= cfg_data[TPP_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the factors into their legal ranges; zero acts as one
	always_comb begin
		if (up_q == '0) begin
			up_eff = UP_W'(1);
		end else if (up_q > UP_W'(UP_MAX)) begin
			up_eff = UP_W'(UP_MAX);
		end else begin
			up_eff = up_q;
		end

		if (dn_q == '0) begin
			dn_eff = DN_W'(1);
		end else if (dn_q > DN_W'(DN_MAX)) begin
			dn_eff = DN_W'(DN_MAX);
		end else begin
			dn_eff = dn_q;
		end

		if (tpp_q == '0) begin
			taps_eff = TAPS_W'(1);
		end else if (32'(tpp_q) > MAX_PHASE_TAPS) begin
			taps_eff = TAPS_W'(MAX_PHASE_TAPS);
		end else begin
			taps_eff = TAPS_W'(tpp_q);
		end
	end

	// Sequence each word: accept; for a push, check, tap walk, drain, scale, emit
	prf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.mode       (mode),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Stores, MAC pipeline, rounding and the output register
	prf_dpath #(
		.MAX_TAPS       (MAX_TAPS),
		.MAX_PHASE_TAPS (MAX_PHASE_TAPS),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_WIDTH     (COEF_WIDTH),
		.TAPS_W         (TAPS_W)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.up           (up_eff),
		.dn           (dn_eff),
		.taps         (taps_eff),
		.sample_in    (sample_in),
		.coef_index   (coef_index),
		.coef_value   (coef_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample_out   (sample_out),
		.is_last      (is_last)
	);

endmodule
